// ===== hw/rtl/tlca_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_pkg: shared constants, types and functions
// Sizes of the ancestor and depth tables, command codes, memory request
// structs and the row address function for the ancestor table.
// ----------------------------------------------------------------------------
package tlca_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 10;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int DEPTH_W   = 10;
  localparam int ROW_LEN   = LEVELS + 1;
  localparam int LVL_W     = $clog2(ROW_LEN);
  localparam int ANC_DEPTH = MAX_NODES * ROW_LEN;
  localparam int ANC_AW    = $clog2(ANC_DEPTH);
  localparam int GAP_W     = ROW_LEN;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;

  typedef struct packed {
    logic              we;
    logic [ANC_AW-1:0] addr;
    node_t             wdata;
  } anc_req_t;

  typedef struct packed {
    logic   we;
    node_t  addr;
    depth_t wdata;
  } dep_req_t;

  // Entry address of level lvl in the row of node.
  function automatic logic [ANC_AW-1:0] row_addr(input node_t node, input lvl_t lvl);
    logic [ANC_AW-1:0] base;
    base = ANC_AW'(node) * ANC_AW'(ROW_LEN);
    return base + ANC_AW'(lvl);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tlca_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tlca_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tlca_ctrl: sequencer and datapath for adds and lowest common ancestor
// Walks the ancestor table one access at a time through a shared row
// address unit, and the depth table for the depth of a node.
// ----------------------------------------------------------------------------
module tlca_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              cmd,
  input  wire tlca_pkg::node_t   node_a,
  input  wire tlca_pkg::node_t   node_b,
  output logic                   busy,
  output logic                   done,
  output tlca_pkg::node_t        ancestor,
  output tlca_pkg::anc_req_t     anc_req,
  input  wire tlca_pkg::node_t   anc_rdata,
  output tlca_pkg::dep_req_t     dep_req,
  input  wire tlca_pkg::depth_t  dep_rdata
);
  import tlca_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_DRD,
    S_A_DWR,
    S_A_RD,
    S_A_WR,
    S_Q_DX,
    S_Q_DY,
    S_Q_DC,
    S_L_RD,
    S_L_WR,
    S_Q_EQ,
    S_J_RX,
    S_J_RY,
    S_J_CMP,
    S_F_RD,
    S_F_OUT
  } state_t;

  state_t           state;
  lvl_t             lvl;
  node_t            x;
  node_t            y;
  node_t            ax;
  depth_t           dx;
  logic [GAP_W-1:0] gap;

  node_t  addr_node;
  lvl_t   addr_lvl;
  node_t  anc_x_v;
  node_t  anc_y_v;
  depth_t dep_y_v;
  depth_t dep_inc;

  // Node zero is the sentinel: its row and depth read as zero whatever the
  // memories hold after reset.
  assign anc_x_v = (x == '0) ? '0 : anc_rdata;
  assign anc_y_v = (y == '0) ? '0 : anc_rdata;
  assign dep_y_v = (y == '0) ? '0 : dep_rdata;
  assign dep_inc = (dep_y_v == DEPTH_MAX) ? DEPTH_MAX : dep_y_v + depth_t'(1);

  assign busy = (state != S_IDLE);

  // Shared row address unit for the ancestor table.
  always_comb begin
    addr_node = y;
    addr_lvl  = lvl;
    case (state)
      S_A_DWR: begin
        addr_node = x;
        addr_lvl  = '0;
      end
      S_A_WR: begin
        addr_node = x;
        addr_lvl  = lvl + lvl_t'(1);
      end
      S_J_RX, S_F_RD: begin
        addr_node = x;
        addr_lvl  = (state == S_F_RD) ? '0 : lvl;
      end
      default: begin
        addr_node = y;
        addr_lvl  = lvl;
      end
    endcase
  end

  always_comb begin
    anc_req.addr  = row_addr(addr_node, addr_lvl);
    anc_req.we    = (state == S_A_DWR) || (state == S_A_WR);
    anc_req.wdata = (state == S_A_DWR) ? y : anc_y_v;
    dep_req.we    = (state == S_A_DWR);
    dep_req.addr  = (state == S_A_DWR || state == S_Q_DX) ? x : y;
    dep_req.wdata = dep_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            x <= node_a;
            y <= node_b;
            if (cmd == CMD_QUERY) begin
              state <= S_Q_DX;
            end else if (node_a != '0) begin
              state <= S_A_DRD;
            end
          end
        end
        S_A_DRD: begin
          state <= S_A_DWR;
        end
        S_A_DWR: begin
          lvl   <= '0;
          state <= S_A_RD;
        end
        S_A_RD: begin
          state <= S_A_WR;
        end
        S_A_WR: begin
          // y follows the chain: it holds the ancestor just written.
          y <= anc_y_v;
          if (lvl == lvl_t'(LEVELS - 1)) begin
            state <= S_IDLE;
          end else begin
            lvl   <= lvl + lvl_t'(1);
            state <= S_A_RD;
          end
        end
        S_Q_DX: begin
          state <= S_Q_DY;
        end
        S_Q_DY: begin
          dx    <= (x == '0) ? '0 : dep_rdata;
          state <= S_Q_DC;
        end
        S_Q_DC: begin
          // Swap so that y is always the deeper node.
          if (dx > dep_y_v) begin
            x   <= y;
            y   <= x;
            gap <= GAP_W'(dx - dep_y_v);
          end else begin
            gap <= GAP_W'(dep_y_v - dx);
          end
          lvl   <= lvl_t'(LEVELS);
          state <= S_L_RD;
        end
        S_L_RD: begin
          if (gap[lvl]) begin
            state <= S_L_WR;
          end else if (lvl == '0) begin
            state <= S_Q_EQ;
          end else begin
            lvl <= lvl - lvl_t'(1);
          end
        end
        S_L_WR: begin
          y <= anc_y_v;
          if (lvl == '0) begin
            state <= S_Q_EQ;
          end else begin
            lvl   <= lvl - lvl_t'(1);
            state <= S_L_RD;
          end
        end
        S_Q_EQ: begin
          if (x == y) begin
            ancestor <= x;
            done     <= 1'b1;
            state    <= S_IDLE;
          end else begin
            lvl   <= lvl_t'(LEVELS);
            state <= S_J_RX;
          end
        end
        S_J_RX: begin
          state <= S_J_RY;
        end
        S_J_RY: begin
          ax    <= anc_x_v;
          state <= S_J_CMP;
        end
        S_J_CMP: begin
          if (ax != anc_y_v) begin
            x <= ax;
            y <= anc_y_v;
          end
          if (lvl == '0) begin
            state <= S_F_RD;
          end else begin
            lvl   <= lvl - lvl_t'(1);
            state <= S_J_RX;
          end
        end
        S_F_RD: begin
          state <= S_F_OUT;
        end
        S_F_OUT: begin
          ancestor <= anc_x_v;
          done     <= 1'b1;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tree_lca_binary_lifting.sv =====
`default_nettype none
// Add: reads the parent depth, writes the depth and level zero entry, then every higher
// level; node zero is dropped at once. Query: reads both depths, lifts the deeper node from
// the top level down, compares the nodes, then lifts both jointly and reads the final parent
// unless the nodes meet after the lift. done is high for the first cycle with busy low; no
// overlap, no stalls. The single read port of the ancestor table serializes these steps.
// Synchronous reset clears the sequencer only; node zero always reads as the sentinel.
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting: lowest common ancestor by binary lifting
// Holds the ancestor and depth tables of a tree built parent first and
// answers lowest common ancestor queries between two nodes.
// ----------------------------------------------------------------------------
module tree_lca_binary_lifting (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic             cmd,
  input  wire tlca_pkg::node_t  node_a,
  input  wire tlca_pkg::node_t  node_b,
  output logic                  done,
  output tlca_pkg::node_t       ancestor
);
  import tlca_pkg::*;

  anc_req_t anc_req;
  dep_req_t dep_req;
  node_t    anc_rdata;
  depth_t   dep_rdata;

  tlca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .node_a    (node_a),
    .node_b    (node_b),
    .busy      (busy),
    .done      (done),
    .ancestor  (ancestor),
    .anc_req   (anc_req),
    .anc_rdata (anc_rdata),
    .dep_req   (dep_req),
    .dep_rdata (dep_rdata)
  );

  tlca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (ANC_DEPTH)
  ) u_anc_ram (
    .clk   (clk),
    .we    (anc_req.we),
    .waddr (anc_req.addr),
    .wdata (anc_req.wdata),
    .raddr (anc_req.addr),
    .rdata (anc_rdata)
  );

  tlca_ram #(
    .WIDTH (DEPTH_W),
    .DEPTH (MAX_NODES)
  ) u_dep_ram (
    .clk   (clk),
    .we    (dep_req.we),
    .waddr (dep_req.addr),
    .wdata (dep_req.wdata),
    .raddr (dep_req.addr),
    .rdata (dep_rdata)
  );

  // An add never produces a result.
  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_ADD) |=> !done)
    else $error("result after an add transaction");

  // A query always keeps the block busy for its walk.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd == CMD_QUERY) |=> (busy && !done))
    else $error("query transaction not held busy");

  // A result is a single pulse and arrives only once the walk is over.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && !$past(done)))
    else $error("result strobe malformed");

  // Table writes happen only inside an add.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (anc_req.we || dep_req.we) |-> busy)
    else $error("table write while idle");

endmodule
`default_nettype wire
